[design/swld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_pkg
// Shared types and constants for the sync-word length-prefixed deframer.
// ----------------------------------------------------------------------------
package swld_pkg;

	localparam int unsigned HEADER_BYTES    = 8;
	localparam int unsigned HC_W            = $clog2(HEADER_BYTES);
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

	// configuration register indexes
	localparam logic CFG_SYNC_WORD   = 1'b0;
	localparam logic CFG_MAX_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		MODE_HEADER  = 2'd0,
		MODE_HUNT    = 2'd1,
		MODE_PAYLOAD = 2'd2,
		MODE_CLOSED  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_HEADER   = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_LAST     = 3'd2,
		EV_EMPTY    = 3'd3,
		EV_OVERSIZE = 3'd4,
		EV_DROPPED  = 3'd5
	} event_t;

	typedef struct packed {
		event_t      event_kind;
		logic [7:0]  payload_byte;
		logic [15:0] packet_length;
	} result_t;

endpackage

[design/swld_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_front
// Header parser: takes one byte per beat, updates the framing state and
// classifies the byte into a result pushed to the queue.
// ----------------------------------------------------------------------------
module swld_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              chunk_last,
	input  logic              q_full,
	output logic              push,
	output swld_pkg::result_t push_data
);
	import swld_pkg::*;

	mode_t            mode_q, mode_n;
	logic [31:0]      win_q, win_n;
	logic [HC_W-1:0]  hc_q, hc_n;
	logic [15:0]      len_q, len_n;
	logic [15:0]      left_q, left_n;
	logic [31:0]      sync_word_q;
	logic [15:0]      max_payload_q;
	logic [31:0]      shifted;
	logic [15:0]      left_dec;
	event_t           kind;
	logic [7:0]       pb;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign shifted  = {data_byte, win_q[31:8]};
	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : left_q;

	always_comb begin
		mode_n = mode_q;
		win_n  = win_q;
		hc_n   = hc_q;
		len_n  = len_q;
		left_n = left_q;
		kind   = EV_HEADER;
		pb     = 8'd0;
		case (mode_q)
			MODE_CLOSED: begin
				kind = EV_DROPPED;
			end
			MODE_PAYLOAD: begin
				pb     = data_byte;
				left_n = left_dec;
				if (left_dec == 16'd0) begin
					kind   = EV_LAST;
					mode_n = MODE_HEADER;
					hc_n   = '0;
					win_n  = '0;
				end else begin
					kind = EV_PAYLOAD;
				end
			end
			MODE_HUNT: begin
				win_n = shifted;
				if (shifted == sync_word_q) begin
					mode_n = MODE_HEADER;
					hc_n   = HC_W'(4);
				end else if (chunk_last) begin
					mode_n = MODE_HEADER;
					hc_n   = '0;
					win_n  = '0;
					kind   = EV_DROPPED;
				end
			end
			default: begin
				if (hc_q == '0)
					len_n = 16'd0;
				if (hc_q < HC_W'(4)) begin
					win_n = shifted;
					if (hc_q == HC_W'(3)) begin
						if (shifted == sync_word_q) begin
							hc_n = HC_W'(4);
						end else if (chunk_last) begin
							hc_n  = '0;
							win_n = '0;
							kind  = EV_DROPPED;
						end else begin
							mode_n = MODE_HUNT;
						end
					end else begin
						hc_n = hc_q + HC_W'(1);
					end
				end else if (hc_q < HC_W'(HEADER_BYTES - 1)) begin
					if (hc_q == HC_W'(4))
						len_n[7:0] = data_byte;
					else if (hc_q == HC_W'(5))
						len_n[15:8] = data_byte;
					hc_n = hc_q + HC_W'(1);
				end else begin
					if (len_q > max_payload_q) begin
						kind   = EV_OVERSIZE;
						mode_n = MODE_CLOSED;
						hc_n   = '0;
					end else if (len_q == 16'd0) begin
						kind  = EV_EMPTY;
						hc_n  = '0;
						win_n = '0;
					end else begin
						mode_n = MODE_PAYLOAD;
						left_n = len_q;
						hc_n   = '0;
						win_n  = '0;
					end
				end
			end
		endcase
	end

	assign push_data.event_kind    = kind;
	assign push_data.payload_byte  = pb;
	assign push_data.packet_length = len_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			win_q  <= '0;
			hc_q   <= '0;
			len_q  <= '0;
			left_q <= '0;
		end else if (push) begin
			mode_q <= mode_n;
			win_q  <= win_n;
			hc_q   <= hc_n;
			len_q  <= len_n;
			left_q <= left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q   <= '0;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SYNC_WORD)
				sync_word_q <= cfg_data;
			else if (cfg_index == CFG_MAX_PAYLOAD)
				max_payload_q <= cfg_data[15:0];
		end
	end

	// a closed session only reopens through reset
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_CLOSED |=> mode_q == MODE_CLOSED)
		else $error("closed session reopened");

	// hunt is entered from the fourth header byte and keeps that count
	a_hunt_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HUNT |-> hc_q == HC_W'(3))
		else $error("header count off during hunt");

	// payload mode starts with a cleared header count and window
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PAYLOAD |-> (hc_q == '0 && win_q == '0))
		else $error("stale header state in payload mode");

endmodule

[design/swld_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_queue
// Two-entry result queue between parser and output stage.
// ----------------------------------------------------------------------------
module swld_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swld_pkg::result_t push_data,
	output logic              full,
	output logic              not_empty,
	input  logic              pop,
	output swld_pkg::result_t pop_data
);
	import swld_pkg::*;

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

[design/swld_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swld_back
// Output register: pulls results from the queue and holds each beat on the
// master side until it is taken.
// ----------------------------------------------------------------------------
module swld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  swld_pkg::result_t q_data,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,
	output logic [2:0]        m_axis_tuser
);
	import swld_pkg::*;

	result_t out_q;
	logic    valid_q;

	assign pop = q_not_empty && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || m_axis_tready)
			valid_q <= q_not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= q_data;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {out_q.packet_length, out_q.payload_byte};
	assign m_axis_tuser  = out_q.event_kind;

endmodule

[design/sync_word_length_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_length_deframer
// Byte-serial deframer for a sync-word, length-prefixed stream.
// ----------------------------------------------------------------------------
// Takes one byte per beat (tlast marks the end of a network chunk) and gives
// exactly one result beat per byte: the byte's class, the payload byte and
// the current length field. A packet is an 8-byte little-endian header (sync
// word, 16-bit length, ignored check word) and then its payload. A sync
// mismatch starts a byte-by-byte hunt that gives up at a chunk end; a length
// above max_payload closes the session until reset. Throughput is one byte
// per clock while the queue is not full. A result is registered in the queue
// and then in the output register before it is valid on the master side; the
// two-entry queue and the output register buffer results while output stalls.
// ----------------------------------------------------------------------------
module sync_word_length_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // chunk_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] packet_length
	output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);
	import swld_pkg::*;

	logic    push;
	logic    q_full;
	logic    q_not_empty;
	logic    pop;
	result_t push_data;
	result_t q_data;

	swld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.chunk_last (s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	swld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.pop_data  (q_data)
	);

	swld_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_data        (q_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

[bench/deframe_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_monitor
// Predicts and checks every result beat of the sync-word deframer.
// ----------------------------------------------------------------------------
// Watches the register port and both streams at each rising edge. Each byte
// taken on the slave side is run through a cycle-free model of the parser,
// and the predicted event is queued. Each beat taken on the master side is
// compared field by field with the oldest queued event.
// ----------------------------------------------------------------------------
module deframe_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // chunk_last
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] packet_length
	input  logic [2:0]  m_axis_tuser,   // [2:0] event_kind
	output int          mismatches,
	output int          outstanding
);
	import swld_pkg::*;

	logic [31:0] sync_word;
	logic [15:0] max_payload;
	mode_t       mode;
	logic [31:0] window;
	logic [2:0]  hdr_count;
	logic [15:0] length_field;
	logic [15:0] bytes_left;
	result_t     pending_events[$];
	int          fail_count = 0;

	function automatic void clear_header();
		mode      = MODE_HEADER;
		hdr_count = '0;
		window    = '0;
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b, input logic chunk_end);
		result_t r;
		r.event_kind   = EV_HEADER;
		r.payload_byte = '0;
		case (mode)
		MODE_CLOSED: begin
			r.event_kind = EV_DROPPED;
		end
		MODE_PAYLOAD: begin
			r.payload_byte = b;
			if (bytes_left != 0)
				bytes_left = bytes_left - 16'd1;
			if (bytes_left == 0) begin
				r.event_kind = EV_LAST;
				clear_header();
			end else begin
				r.event_kind = EV_PAYLOAD;
			end
		end
		MODE_HUNT: begin
			window = {b, window[31:8]};
			if (window == sync_word) begin
				mode      = MODE_HEADER;
				hdr_count = 3'd4;
			end else if (chunk_end) begin
				// chunk ended while hunting: start over at the next chunk
				clear_header();
				r.event_kind = EV_DROPPED;
			end
		end
		default: begin
			if (hdr_count == 0)
				length_field = '0;
			if (hdr_count < 4) begin
				window = {b, window[31:8]};
				if (hdr_count == 3) begin
					if (window == sync_word) begin
						hdr_count = 3'd4;
					end else if (chunk_end) begin
						clear_header();
						r.event_kind = EV_DROPPED;
					end else begin
						mode = MODE_HUNT;
					end
				end else begin
					hdr_count = hdr_count + 3'd1;
				end
			end else if (hdr_count < HEADER_BYTES - 1) begin
				if (hdr_count == 4)
					length_field[7:0] = b;
				else if (hdr_count == 5)
					length_field[15:8] = b;
				hdr_count = hdr_count + 3'd1;
			end else begin
				// last header byte: check word ignored, length decides
				if (length_field > max_payload) begin
					r.event_kind = EV_OVERSIZE;
					mode         = MODE_CLOSED;
					hdr_count    = '0;
				end else if (length_field == 0) begin
					r.event_kind = EV_EMPTY;
					clear_header();
				end else begin
					mode       = MODE_PAYLOAD;
					bytes_left = length_field;
					hdr_count  = '0;
					window     = '0;
				end
			end
		end
		endcase
		r.packet_length = length_field;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sync_word    = '0;
			max_payload  = MAX_PAYLOAD_RST;
			length_field = '0;
			bytes_left   = '0;
			clear_header();
			pending_events.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SYNC_WORD)
					sync_word = cfg_data;
				else
					max_payload = cfg_data[15:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_events.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual kind %0d byte %0d length %0d",
						$time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
					fail_count++;
				end else begin
					want = pending_events.pop_front();
					if (want.event_kind != m_axis_tuser) begin
						$display("%0t: event_kind expected %0d actual %0d",
							$time, want.event_kind, m_axis_tuser);
						fail_count++;
					end
					if (want.payload_byte != m_axis_tdata[7:0]) begin
						$display("%0t: payload_byte expected %0d actual %0d",
							$time, want.payload_byte, m_axis_tdata[7:0]);
						fail_count++;
					end
					if (want.packet_length != m_axis_tdata[23:8]) begin
						$display("%0t: packet_length expected %0d actual %0d",
							$time, want.packet_length, m_axis_tdata[23:8]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_events.push_back(deframe_byte(s_axis_tdata, s_axis_tlast));
		end
		mismatches  <= fail_count;
		outstanding <= pending_events.size();
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sync-word length-prefixed deframer.
// ----------------------------------------------------------------------------
// A short directed stream covers the packet, empty packet, split header,
// failed sync and hunt cases. Random phases then run well-formed packets
// with random content and noise under several register settings, with
// random gaps on the input and random stalls on the output. The run ends
// with an oversize header that closes the session for good.
// ----------------------------------------------------------------------------
module testbench;
	import swld_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = CFG_SYNC_WORD;
	logic [31:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	int          mismatches;
	int          outstanding;

	int          cycles  = 0;
	int          sent    = 0;
	bit          gaps_on = 1'b1;
	logic [31:0] cur_sync;

	// {chunk_last, data_byte}; sync word and max_payload at reset values
	logic [8:0] directed [23] = '{
		// length-2 packet, chunk end inside the header
		9'h000, 9'h100, 9'h000, 9'h000, 9'h002, 9'h000, 9'h0AA, 9'h055,
		9'h0FF, 9'h100,
		// sync fails on the fourth byte, which also ends the chunk
		9'h001, 9'h002, 9'h003, 9'h104,
		// one junk byte, hunt matches on a chunk end, empty packet
		9'h077, 9'h000, 9'h000, 9'h000, 9'h100, 9'h000, 9'h000, 9'h0C3,
		9'h03C
	};

	sync_word_length_deframer u_top (.*);
	deframe_monitor u_monitor (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output side: random stall before each beat, stalls switched off now and then
	initial begin : sink
		int stall;
		int beats;
		bit stalls_on;
		beats     = 0;
		stalls_on = 1'b1;
		forever begin
			if (beats % 50 == 0)
				stalls_on = $urandom_range(0, 2) != 0;
			stall = stalls_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			beats++;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic chunk_end);
		int gap;
		gap = gaps_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= chunk_end;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		if (sent % 40 == 0)
			gaps_on = $urandom_range(0, 2) != 0;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_header(input logic [31:0] sync, input logic [15:0] len, input bit split);
		logic [63:0] hdr;
		logic        chunk_end;
		int          i;
		hdr = {16'($urandom), len, sync};
		for (i = 0; i < HEADER_BYTES; i++) begin
			chunk_end = split && $urandom_range(0, 7) == 0;
			if (i == HEADER_BYTES - 1 && len == 0)
				chunk_end = $urandom_range(0, 1) != 0;
			send_byte(hdr[8*i +: 8], chunk_end);
		end
	endtask

	task automatic send_packet(input logic [31:0] sync, input logic [15:0] len, input bit split);
		int i;
		send_header(sync, len, split);
		for (i = 0; i < len; i++)
			send_byte(8'($urandom), (i == len - 1) ? $urandom_range(0, 1) != 0
				: split && $urandom_range(0, 7) == 0);
	endtask

	task automatic send_noise(input logic [31:0] sync, input logic [15:0] len);
		int n;
		int i;
		case ($urandom_range(0, 2))
		0: begin
			// junk ahead of a packet: the hunt has to find the sync word
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom), 1'b0);
			send_packet(sync, len, 1'b0);
		end
		1: begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom), i == n - 1);
		end
		default: begin
			send_packet(sync ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3))),
				len, 1'b1);
		end
		endcase
	endtask

	task automatic run_phase(input logic [31:0] sync, input logic [15:0] limit, input bit noisy,
			input int budget);
		int          start;
		int          cap;
		logic [15:0] len;
		cur_sync = sync;
		write_reg(CFG_SYNC_WORD, sync);
		write_reg(CFG_MAX_PAYLOAD, {16'h0, limit});
		start = sent;
		while (sent - start < budget) begin
			// lengths never exceed the limit, so the session stays open
			cap = (limit < 24) ? limit : 24;
			len = 16'($urandom_range(0, cap));
			if ($urandom_range(0, 15) == 0 && limit <= 300)
				len = limit;
			if (noisy && $urandom_range(0, 3) == 0)
				send_noise(sync, len);
			else
				send_packet(sync, len, 1'b1);
		end
		drain();
	endtask

	initial begin : stimulus
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < 23; i++)
			send_byte(directed[i][7:0], directed[i][8]);
		drain();

		run_phase($urandom, 16'd40, 1'b1, 260);
		run_phase(32'hFFFF_FFFF, 16'd0, 1'b0, 160);
		run_phase($urandom, 16'hFFFF, 1'b1, 260);
		run_phase(32'h0000_0000, 16'd1, 1'b0, 160);
		run_phase($urandom, 16'd300, 1'b1, 300);

		// oversize closes the session; later bytes and writes change nothing
		write_reg(CFG_MAX_PAYLOAD, 32'h0000_FFFE);
		send_header(cur_sync, 16'hFFFF, 1'b0);
		for (i = 0; i < 4; i++)
			send_byte(8'($urandom), 1'($urandom_range(0, 1)));
		drain();
		write_reg(CFG_MAX_PAYLOAD, 32'h0000_FFFF);
		write_reg(CFG_SYNC_WORD, 32'h0000_0000);
		for (i = 0; i < 8; i++)
			send_byte(8'h00, i == 7);
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
design/swld_pkg.sv
design/swld_front.sv
design/swld_queue.sv
design/swld_back.sv
design/sync_word_length_deframer.sv
bench/deframe_monitor.sv
bench/testbench.sv
